### hw/rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the delay task scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int unsigned MaxTasks = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CntW     = 4;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_TICK   = 3'd1,
    OP_SWITCH = 3'd2,
    OP_RETRY  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_SEARCH,
    S_FOUND
  } state_e;

endpackage

### hw/rtl/delay_task_scheduler.sv
// ----------------------------------------------------------------------------
// delay_task_scheduler
// Task table of a round-robin cooperative scheduler: add task, tick,
// delay and switch, retry search, read lowest stack pointer.
//
//  channel  | handshake      | ports
//  ---------+----------------+-----------------------------------------------
//  command  | start, busy    | opcode_i, stack_pointer_i, entry_address_i,
//           |                | delay_ticks_i, tick_amount_i, task_index_i
//  result   | done_o strobe  | status_o, task_count_o, next_task_o,
//           |                | restore_sp_o, start_valid_o, start_address_o,
//           |                | min_stack_o
//
//  Add, read and unused opcodes: result in the cycle after start, no busy.
//  Tick: runs over all T defined tasks; one delay entry per cycle goes
//  through the shared subtract and compare unit.
//  Switch and retry: up to T entries, one tested per cycle; then the
//  S_FOUND state for the registered read of the saved stack memory.
//  Reset takes effect at once; there is no clearing pass. done_o lasts one
//  cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module delay_task_scheduler import dts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] stack_pointer_i,
  input  logic [15:0] entry_address_i,
  input  logic [15:0] delay_ticks_i,
  input  logic [7:0]  tick_amount_i,
  input  logic [2:0]  task_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  task_count_o,
  output logic [2:0]  next_task_o,
  output logic [15:0] restore_sp_o,
  output logic        start_valid_o,
  output logic [15:0] start_address_o,
  output logic [15:0] min_stack_o
);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [7:0]        amt_q, amt_d;
  logic [IdxW-1:0]   running_q, running_d;
  logic [CntW-1:0]   defined_q, defined_d;

  logic [15:0]       pending_q [MaxTasks];
  logic [15:0]       pending_d [MaxTasks];
  logic [15:0]       delay_q   [MaxTasks];
  logic [15:0]       delay_d   [MaxTasks];
  logic [15:0]       lowest_q  [MaxTasks];
  logic [15:0]       lowest_d  [MaxTasks];

  logic [15:0]       saved_mem [MaxTasks];
  logic              sv_we;
  logic [IdxW-1:0]   sv_waddr;
  logic [15:0]       sv_wdata;
  logic [15:0]       sv_rdata_q;

  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   next_q, next_d;
  logic [15:0]       rsp_q, rsp_d;
  logic              sval_q, sval_d;
  logic [15:0]       saddr_q, saddr_d;
  logic [15:0]       mins_q, mins_d;

  logic              accept;
  logic [CntW-1:0]   idx_inc, run_inc, cnt_inc;
  logic [IdxW-1:0]   idx_nxt, run_nxt;
  logic [IdxW-1:0]   rd_idx;
  logic [15:0]       lowest_rd;
  logic [15:0]       dly_cur;
  logic [15:0]       amt_ext;
  logic [IdxW-1:0]   add_idx;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);

  assign idx_inc   = {1'b0, idx_q} + CntW'(1);
  assign idx_nxt   = (idx_inc == defined_q) ? '0 : idx_inc[IdxW-1:0];
  assign run_inc   = {1'b0, running_q} + CntW'(1);
  assign run_nxt   = (run_inc == defined_q) ? '0 : run_inc[IdxW-1:0];
  assign cnt_inc   = {1'b0, cnt_q} + CntW'(1);
  assign add_idx   = defined_q[IdxW-1:0];

  assign rd_idx    = (op_e'(opcode_i) == OP_READ) ? task_index_i : running_q;
  assign lowest_rd = lowest_q[rd_idx];
  assign dly_cur   = delay_q[idx_q];
  assign amt_ext   = {8'b0, amt_q};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    amt_d     = amt_q;
    running_d = running_q;
    defined_d = defined_q;
    pending_d = pending_q;
    delay_d   = delay_q;
    lowest_d  = lowest_q;
    sv_we     = 1'b0;
    sv_waddr  = running_q;
    sv_wdata  = stack_pointer_i;
    done_d    = 1'b0;
    status_d  = status_q;
    count_d   = count_q;
    next_d    = next_q;
    rsp_d     = rsp_q;
    sval_d    = sval_q;
    saddr_d   = saddr_q;
    mins_d    = mins_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = STAT_DONE;
          count_d  = '0;
          next_d   = '0;
          rsp_d    = '0;
          sval_d   = 1'b0;
          saddr_d  = '0;
          mins_d   = '0;
          case (op_e'(opcode_i))
            OP_ADD: begin
              done_d      = 1'b1;
              lowest_d[0] = 16'hFFFF;
              pending_d[0] = '0;
              if (defined_q >= CntW'(MaxTasks)) begin
                status_d = STAT_FULL;
              end else begin
                sv_we              = 1'b1;
                sv_waddr           = add_idx;
                pending_d[add_idx] = entry_address_i;
                delay_d[add_idx]   = '0;
                lowest_d[add_idx]  = 16'hFFFF;
                defined_d          = defined_q + CntW'(1);
                count_d            = defined_q + CntW'(1);
              end
            end
            OP_TICK: begin
              if (stack_pointer_i < lowest_rd) begin
                lowest_d[running_q] = stack_pointer_i;
              end
              amt_d   = tick_amount_i;
              idx_d   = '0;
              state_d = S_TICK;
            end
            OP_SWITCH: begin
              sv_we              = 1'b1;
              delay_d[running_q] = delay_ticks_i;
              idx_d              = run_nxt;
              cnt_d              = '0;
              state_d            = S_SEARCH;
            end
            OP_RETRY: begin
              idx_d   = run_nxt;
              cnt_d   = '0;
              state_d = S_SEARCH;
            end
            OP_READ: begin
              done_d = 1'b1;
              if ({1'b0, task_index_i} < defined_q) begin
                mins_d = lowest_rd;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_TICK: begin
        delay_d[idx_q] = (dly_cur > amt_ext) ? (dly_cur - amt_ext) : '0;
        if (idx_inc == defined_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_inc[IdxW-1:0];
        end
      end
      S_SEARCH: begin
        if (dly_cur == '0) begin
          state_d = S_FOUND;
        end else if (cnt_inc == defined_q) begin
          status_d = STAT_NONE;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_nxt;
          cnt_d = cnt_inc[IdxW-1:0];
        end
      end
      S_FOUND: begin
        running_d = idx_q;
        next_d    = idx_q;
        rsp_d     = sv_rdata_q;
        if (pending_q[idx_q] != '0) begin
          sval_d           = 1'b1;
          saddr_d          = pending_q[idx_q];
          pending_d[idx_q] = '0;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= '0;
      defined_q <= CntW'(1);
      done_q    <= 1'b0;
      for (int i = 0; i < MaxTasks; i++) begin
        pending_q[i] <= '0;
        delay_q[i]   <= '0;
        lowest_q[i]  <= 16'hFFFF;
      end
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      defined_q <= defined_d;
      done_q    <= done_d;
      pending_q <= pending_d;
      delay_q   <= delay_d;
      lowest_q  <= lowest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    amt_q    <= amt_d;
    status_q <= status_d;
    count_q  <= count_d;
    next_q   <= next_d;
    rsp_q    <= rsp_d;
    sval_q   <= sval_d;
    saddr_q  <= saddr_d;
    mins_q   <= mins_d;
  end

  always_ff @(posedge clk_i) begin
    if (sv_we) begin
      saved_mem[sv_waddr] <= sv_wdata;
    end
    sv_rdata_q <= saved_mem[idx_q];
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign task_count_o    = count_q;
  assign next_task_o     = next_q;
  assign restore_sp_o    = rsp_q;
  assign start_valid_o   = sval_q;
  assign start_address_o = saddr_q;
  assign min_stack_o     = mins_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_defined_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (defined_q >= CntW'(1)) && (defined_q <= CntW'(MaxTasks)))
    else $error("defined task count out of range");

  a_running_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, running_q} < defined_q)
    else $error("running task beyond defined tasks");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_NONE) |-> (!start_valid_o && restore_sp_o == '0))
    else $error("no-ready result carries task data");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> ({1'b0, cnt_q} < defined_q))
    else $error("search visited more entries than defined");
`endif

endmodule
